FILE: rtl/efce_pkg.sv
// ----------------------------------------------------------------------------
// efce_pkg
// Shared types, constants and helpers for the escaped frame checksum encoder.
// ----------------------------------------------------------------------------
package efce_pkg;

  localparam int SlotCount = 8;
  localparam int SlotW     = $clog2(SlotCount);

  // Order in which the logical bytes of one item go out
  localparam logic [SlotW-1:0] SLOT_BEGIN   = 3'd0;
  localparam logic [SlotW-1:0] SLOT_CMD     = 3'd1;
  localparam logic [SlotW-1:0] SLOT_ERR     = 3'd2;
  localparam logic [SlotW-1:0] SLOT_SEQ     = 3'd3;
  localparam logic [SlotW-1:0] SLOT_PAYLOAD = 3'd4;
  localparam logic [SlotW-1:0] SLOT_SUM_HI  = 3'd5;
  localparam logic [SlotW-1:0] SLOT_SUM_LO  = 3'd6;
  localparam logic [SlotW-1:0] SLOT_END     = 3'd7;

  typedef enum logic [2:0] {
    REG_BEGIN   = 3'd0,
    REG_END     = 3'd1,
    REG_ESCAPE  = 3'd2,
    REG_COMMAND = 3'd3,
    REG_ERROR   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] begin_c;
    logic [7:0] end_c;
    logic [7:0] esc_c;
  } codes_t;

  typedef struct packed {
    logic [SlotCount-1:0]       mask;
    logic [SlotCount-1:0][7:0]  vals;
    logic [7:0]                 seq;
  } item_t;

  function automatic logic is_special(input logic [7:0] b, input codes_t c);
    return (b == c.begin_c) || (b == c.end_c) || (b == c.esc_c);
  endfunction

endpackage

FILE: rtl/escaped_frame_checksum_encoder.sv
// ----------------------------------------------------------------------------
// escaped_frame_checksum_encoder
// Byte-stuffing framer with a 16-bit additive checksum.
//
//   channel  | dir | handshake                    | content
//   ---------+-----+------------------------------+--------------------------
//   s_axis   | in  | s_axis_tvalid/s_axis_tready  | payload byte, has_byte,
//            |     |                              | end_of_command
//   m_axis   | out | m_axis_tvalid/m_axis_tready  | out byte, end_of_run,
//            |     |                              | frame_sequence
//   cfg      | in  | cfg_we_i                     | register index and data
//
// One output byte per cycle while m_axis accepts. An item produces 1..14
// bytes; the one-item buffer and the output register let the
// next item enter on the cycle its predecessor's last byte moves into the
// output register. An item that produces nothing is accepted without a load.
// Reset clears the frame state and loads the default codes.
// Back-pressure on m_axis holds the output register and stalls s_axis.
// ----------------------------------------------------------------------------
module escaped_frame_checksum_encoder import efce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] payload_byte
  input  logic [0:0]  s_axis_tuser,   // [0] has_byte
  input  logic        s_axis_tlast,   // end_of_command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [15:8] frame_sequence
  output logic        m_axis_tlast,   // end_of_run
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);

  logic [7:0]  begin_q, end_q, esc_q, cmd_q, err_q;
  logic        in_frame_q, in_frame_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  seq_q, seq_d;

  codes_t      codes;
  item_t       item;
  logic        s_fire;
  logic        load;
  logic        can_load;
  logic        busy;
  logic [7:0]  c1, c2, c3, c4;
  logic [7:0]  seq_next;
  logic [15:0] sum_base;
  logic        has_byte;

  assign codes    = '{begin_c: begin_q, end_c: end_q, esc_c: esc_q};
  assign has_byte = s_axis_tuser[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      begin_q <= 8'hF0;
      end_q   <= 8'hF1;
      esc_q   <= 8'hF2;
      cmd_q   <= 8'h00;
      err_q   <= 8'h00;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_BEGIN:   begin_q <= cfg_data_i;
        REG_END:     end_q   <= cfg_data_i;
        REG_ESCAPE:  esc_q   <= cfg_data_i;
        REG_COMMAND: cmd_q   <= cfg_data_i;
        REG_ERROR:   err_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next sequence: at most three specials to step over
  assign c1 = seq_q + 8'd1;
  assign c2 = seq_q + 8'd2;
  assign c3 = seq_q + 8'd3;
  assign c4 = seq_q + 8'd4;

  always_comb begin
    priority if (!is_special(c1, codes)) begin
      seq_next = c1;
    end else if (!is_special(c2, codes)) begin
      seq_next = c2;
    end else if (!is_special(c3, codes)) begin
      seq_next = c3;
    end else begin
      seq_next = c4;
    end
  end

  assign s_axis_tready = can_load;
  assign s_fire        = s_axis_tvalid && can_load;

  always_comb begin
    seq_d      = in_frame_q ? seq_q : seq_next;
    sum_base   = in_frame_q ? sum_q : ({8'd0, cmd_q} + {8'd0, err_q});
    sum_d      = sum_base + {8'd0, (has_byte ? s_axis_tdata : 8'd0)};
    in_frame_d = !s_axis_tlast;

    item.mask                = '0;
    item.mask[SLOT_BEGIN]    = !in_frame_q;
    item.mask[SLOT_CMD]      = !in_frame_q;
    item.mask[SLOT_ERR]      = !in_frame_q;
    item.mask[SLOT_SEQ]      = !in_frame_q;
    item.mask[SLOT_PAYLOAD]  = has_byte;
    item.mask[SLOT_SUM_HI]   = s_axis_tlast;
    item.mask[SLOT_SUM_LO]   = s_axis_tlast;
    item.mask[SLOT_END]      = s_axis_tlast;
    item.vals                = '0;
    item.vals[SLOT_BEGIN]    = begin_q;
    item.vals[SLOT_CMD]      = cmd_q;
    item.vals[SLOT_ERR]      = err_q;
    item.vals[SLOT_SEQ]      = seq_d;
    item.vals[SLOT_PAYLOAD]  = s_axis_tdata;
    item.vals[SLOT_SUM_HI]   = sum_d[15:8];
    item.vals[SLOT_SUM_LO]   = sum_d[7:0];
    item.vals[SLOT_END]      = end_q;
    item.seq                 = seq_d;
  end

  assign load = s_fire && (item.mask != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      sum_q      <= '0;
      seq_q      <= '0;
    end else if (s_fire) begin
      in_frame_q <= in_frame_d;
      sum_q      <= sum_d;
      seq_q      <= seq_d;
    end
  end

  efce_serializer u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .item_i        (item),
    .codes_i       (codes),
    .can_load_o    (can_load),
    .busy_o        (busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // new frame never picks a special code as its sequence number
  a_seq_not_special: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && !in_frame_q |=> (seq_q != $past(begin_q)) && (seq_q != $past(end_q))
                              && (seq_q != $past(esc_q)))
    else $error("sequence number hit a special code");

  // the header always leaves something to send
  a_header_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && !in_frame_q |=> busy)
    else $error("frame start produced no output");

  // checksum restarts from command plus error on a frame start
  a_sum_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && !in_frame_q && !has_byte |=>
      sum_q == ({8'd0, $past(cmd_q)} + {8'd0, $past(err_q)}))
    else $error("checksum start value wrong");

  // a closing item ends the frame
  a_frame_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tlast |=> !in_frame_q)
    else $error("frame still open after its last item");

endmodule

FILE: rtl/efce_serializer.sv
// ----------------------------------------------------------------------------
// efce_serializer
// Holds one item's logical bytes, escapes all but the begin and end bytes and
// sends one byte per cycle through an output register while m_axis accepts.
// ----------------------------------------------------------------------------
module efce_serializer import efce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  item_t       item_i,
  input  codes_t      codes_i,
  output logic        can_load_o,
  output logic        busy_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [15:8] frame_sequence
  output logic        m_axis_tlast    // end_of_run
);

  logic [SlotCount-1:0]      mask_q, mask_d;
  logic [SlotCount-1:0][7:0] vals_q;
  logic [7:0]                seq_q;
  logic                      phase_q, phase_d;
  logic                      ovalid_q, ovalid_d;
  logic [7:0]                obyte_q;
  logic [7:0]                oseq_q;
  logic                      olast_q;

  logic [SlotW-1:0]     idx;
  logic [SlotCount-1:0] rest;
  logic [7:0]           cur_v;
  logic [7:0]           byte_out;
  logic                 escapable;
  logic                 esc_first;
  logic                 last_byte;
  logic                 busy;
  logic                 adv;

  always_comb begin
    idx = '0;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        idx = SlotW'(i);
      end
    end
  end

  assign busy      = |mask_q;
  assign cur_v     = vals_q[idx];
  assign escapable = (idx != SLOT_BEGIN) && (idx != SLOT_END);
  assign esc_first = escapable && is_special(cur_v, codes_i) && !phase_q;
  assign byte_out  = esc_first ? codes_i.esc_c :
                     (phase_q ? (codes_i.esc_c ^ cur_v) : cur_v);
  assign rest      = mask_q & ~(SlotCount'(1) << idx);
  assign last_byte = (rest == '0) && !esc_first;
  assign adv       = busy && (!ovalid_q || m_axis_tready);

  assign can_load_o = !busy || (adv && last_byte);
  assign busy_o     = busy;

  always_comb begin
    mask_d  = mask_q;
    phase_d = phase_q;
    if (load_i) begin
      mask_d  = item_i.mask;
      phase_d = 1'b0;
    end else if (adv) begin
      phase_d = esc_first;
      if (!esc_first) begin
        mask_d = rest;
      end
    end
  end

  assign ovalid_d = adv ? 1'b1 : (m_axis_tready ? 1'b0 : ovalid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= '0;
      phase_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      mask_q   <= mask_d;
      phase_q  <= phase_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      vals_q <= item_i.vals;
      seq_q  <= item_i.seq;
    end
    if (adv) begin
      obyte_q <= byte_out;
      oseq_q  <= seq_q;
      olast_q <= last_byte;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {oseq_q, obyte_q};
  assign m_axis_tlast  = olast_q;

endmodule
